// ===== rtl/tpapc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpapc_pkg
// Shared constants for the TCP port and address packet counter: frame
// layout, protocol codes, register indexes, reset values and bucket codes.
// ----------------------------------------------------------------------------
package tpapc_pkg;

  localparam int COUNT_WIDTH = 64;

  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
  localparam logic [POS_W-1:0] ETH_LEN = 7'd14;
  localparam int IP_LEN = 20;
  localparam logic [POS_W-1:0] IP_LAST_POS = 7'd33;
  localparam logic [POS_W-1:0] TCP_LAST_OFS = 7'd19;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam int IP_PROTO_IDX = 9;
  localparam int IP_SRC_IDX = 12;
  localparam int IP_DST_IDX = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_B = 2'd2;

  localparam logic [15:0] WATCH_PORT_RST = 16'd17883;
  localparam logic [31:0] ADDR_A_RST = 32'h2BAF_E412;
  localparam logic [31:0] ADDR_B_RST = 32'h2BAF_E512;

  localparam int NUM_BUCKETS = 3;
  localparam logic [1:0] BUCKET_OTHER = 2'd0;
  localparam logic [1:0] BUCKET_A = 2'd1;
  localparam logic [1:0] BUCKET_B = 2'd2;

endpackage

// ===== rtl/tcp_port_address_packet_counter_top.sv =====
// ----------------------------------------------------------------------------
// tcp_port_address_packet_counter_top
// Classifies IPv4/TCP frames by watched port and target address and keeps
// one wrapping packet counter per bucket.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one Ethernet frame byte per item, wire order, in_tlast on the last
//           byte. Bytes past position 127 are ignored.
//   out_* : one item per frame, issued for the item that carries in_tlast.
//           out_tuser flags whether a counter was bumped and which bucket;
//           out_tdata holds the new counter value (zero when not counted).
//   cfg_* : register writes (watch port, address A, address B), always ready;
//           write only while no frame is in flight.
// A result is registered once its last byte is accepted. Throughput: one byte
// per cycle while in_tready is high; all work is capture and compare done in the
// accepting cycle, with the result landing in the output or skid register.
// A two-entry output (output register plus skid register) lets bytes keep
// flowing while a result waits; in_tready drops only while both are full.
// Reset (synchronous, rst_n low) clears the counters, the frame capture
// state and the output queue and restores the register defaults.
// ----------------------------------------------------------------------------
module tcp_port_address_packet_counter_top
  import tpapc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // end_of_frame
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [63:0] new_count
  output logic [2:0]           out_tuser,  // [0] counted, [2:1] bucket
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [15:0] watch_port_r;
  logic [31:0] addr_a_r, addr_b_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [7:0] ip_hdr_r [IP_LEN];
  logic [7:0] hdr_view [IP_LEN];
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_BUCKETS];

  logic in_acc, out_take;
  logic [POS_W-1:0] tcp_off;
  logic [1:0] port_byte;
  logic [31:0] src_addr, dst_addr;
  logic [15:0] src_port, dst_port;
  logic hit;
  logic [1:0] bkt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic res_valid;
  logic res_counted;
  logic [1:0] res_bkt;
  logic [COUNT_WIDTH-1:0] res_cnt;

  logic out_valid_r, skid_valid_r;
  logic out_counted_r, skid_counted_r;
  logic [1:0] out_bkt_r, skid_bkt_r;
  logic [COUNT_WIDTH-1:0] out_cnt_r, skid_cnt_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_acc = in_tvalid && in_tready;
  assign out_take = out_valid_r && out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_port_r <= WATCH_PORT_RST;
      addr_a_r <= ADDR_A_RST;
      addr_b_r <= ADDR_B_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WATCH_PORT: watch_port_r <= cfg_data[15:0];
        CFG_ADDR_A:     addr_a_r <= cfg_data;
        CFG_ADDR_B:     addr_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // header bytes as seen after this item: forward the byte being written
  always_comb begin
    for (int i = 0; i < IP_LEN; i++) begin
      hdr_view[i] = (pos_r == ETH_LEN + POS_W'(i)) ? in_tdata : ip_hdr_r[i];
    end
  end

  assign tcp_off = ETH_LEN + {1'b0, hdr_view[0][3:0], 2'b00};
  assign port_byte = 2'(pos_r - tcp_off);

  always_comb begin
    etype_nxt = etype_r;
    if (pos_r == POS_ETYPE_HI || pos_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_r[7:0], in_tdata};
    end
    ports_nxt = ports_r;
    if (pos_r >= ETH_LEN && pos_r >= tcp_off && pos_r < tcp_off + POS_W'(4)) begin
      case (port_byte)
        2'd0: ports_nxt[31:24] = in_tdata;
        2'd1: ports_nxt[23:16] = in_tdata;
        2'd2: ports_nxt[15:8] = in_tdata;
        default: ports_nxt[7:0] = in_tdata;
      endcase
    end
    if (in_tlast) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign src_addr = {hdr_view[IP_SRC_IDX], hdr_view[IP_SRC_IDX+1],
                     hdr_view[IP_SRC_IDX+2], hdr_view[IP_SRC_IDX+3]};
  assign dst_addr = {hdr_view[IP_DST_IDX], hdr_view[IP_DST_IDX+1],
                     hdr_view[IP_DST_IDX+2], hdr_view[IP_DST_IDX+3]};
  assign src_port = ports_nxt[31:16];
  assign dst_port = ports_nxt[15:0];

  always_comb begin
    hit = pos_r >= IP_LAST_POS && etype_nxt == ETHERTYPE_IPV4
       && hdr_view[IP_PROTO_IDX] == PROTO_TCP
       && pos_r >= tcp_off + TCP_LAST_OFS
       && (src_port == watch_port_r || dst_port == watch_port_r);
    if (src_addr == addr_a_r || dst_addr == addr_a_r) begin
      bkt = BUCKET_A;
    end else if (src_addr == addr_b_r || dst_addr == addr_b_r) begin
      bkt = BUCKET_B;
    end else begin
      bkt = BUCKET_OTHER;
    end
  end

  assign cnt_inc = cnt_r[bkt] + COUNT_WIDTH'(1);
  assign res_valid = in_acc && in_tlast;
  assign res_counted = hit;
  assign res_bkt = hit ? bkt : BUCKET_OTHER;
  assign res_cnt = hit ? cnt_inc : '0;

  // frame capture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      etype_r <= '0;
      ports_r <= '0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      etype_r <= in_tlast ? 16'd0 : etype_nxt;
      ports_r <= in_tlast ? 32'd0 : ports_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < IP_LEN; i++) begin
      if (in_acc && pos_r == ETH_LEN + POS_W'(i)) begin
        ip_hdr_r[i] <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (res_valid && hit) begin
      cnt_r[bkt] <= cnt_inc;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_counted_r <= skid_counted_r;
        out_bkt_r <= skid_bkt_r;
        out_cnt_r <= skid_cnt_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_counted_r <= res_counted;
        skid_bkt_r <= res_bkt;
        skid_cnt_r <= res_cnt;
      end else begin
        out_counted_r <= res_counted;
        out_bkt_r <= res_bkt;
        out_cnt_r <= res_cnt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = 64'(out_cnt_r);
  assign out_tuser = {out_bkt_r, out_counted_r};

  // assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while output register is empty");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[2:1] == BUCKET_OTHER && out_tdata == 64'd0)
    else $error("uncounted result carries a bucket or count");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'd3)
    else $error("bucket out of range");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> pos_r == '0 && etype_r == 16'd0 && ports_r == 32'd0)
    else $error("frame state not cleared after last byte");

  a_count_bump: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && hit && !skid_valid_r && (!out_valid_r || out_take)
    |=> out_tdata == 64'(cnt_r[out_tuser[2:1]]))
    else $error("reported count differs from stored counter");

endmodule
